// ===== rtl/dtfp_pkg.sv =====
`default_nettype none
package dtfp_pkg;

  localparam int unsigned MANT_W = 64;
  localparam int unsigned SCALE_W = 30;
  localparam int unsigned PROD_W = MANT_W + SCALE_W;
  localparam int unsigned DEN_W = 60;
  localparam int unsigned FCNT_W = 5;
  localparam int unsigned FBITS_W = 6;
  localparam int unsigned EXPD_W = 4;

  localparam logic [FCNT_W-1:0] MAX_FRACTION_DIGITS = 5'd18;
  localparam int unsigned DEF_RESULT_WIDTH = 64;
  localparam logic [FBITS_W-1:0] FBITS_RESET = 6'd16;

  typedef enum logic [1:0] {
    PH_WS,
    PH_INT,
    PH_FRAC,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    EX_SEARCH,
    EX_NEXT,
    EX_DONE
  } exp_state_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_MUL_LO,
    SC_MUL_HI,
    SC_SUM,
    SC_DIV,
    SC_DONE
  } scale_state_t;

  typedef struct packed {
    logic              neg;
    logic [MANT_W-1:0] mantissa;
    logic [FCNT_W-1:0] frac_count;
    logic              mant_sat;
    logic [EXPD_W-1:0] exp_digit;
    logic              exp_bad;
  } scan_snap_t;

  function automatic logic [DEN_W-1:0] pow10(input logic [FCNT_W-1:0] n);
    logic [DEN_W-1:0] p;
    case (n)
      5'd0:    p = 60'd1;
      5'd1:    p = 60'd10;
      5'd2:    p = 60'd100;
      5'd3:    p = 60'd1000;
      5'd4:    p = 60'd10000;
      5'd5:    p = 60'd100000;
      5'd6:    p = 60'd1000000;
      5'd7:    p = 60'd10000000;
      5'd8:    p = 60'd100000000;
      5'd9:    p = 60'd1000000000;
      5'd10:   p = 60'd10000000000;
      5'd11:   p = 60'd100000000000;
      5'd12:   p = 60'd1000000000000;
      5'd13:   p = 60'd10000000000000;
      5'd14:   p = 60'd100000000000000;
      5'd15:   p = 60'd1000000000000000;
      5'd16:   p = 60'd10000000000000000;
      5'd17:   p = 60'd100000000000000000;
      5'd18:   p = 60'd1000000000000000000;
      default: p = 60'd1000000000000000000;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dtfp_char_scan.sv =====
`default_nettype none
module dtfp_char_scan (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [7:0]          char_code,
  input  wire logic                last_char,
  output dtfp_pkg::scan_snap_t     snap
);

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_E_UP  = 8'd69;
  localparam logic [7:0] CH_E_LOW = 8'd101;

  localparam int unsigned ACC_W = dtfp_pkg::MANT_W + 4;

  dtfp_pkg::phase_t                    phase, phase_next;
  dtfp_pkg::exp_state_t                ex_state, ex_state_next;
  logic                                neg, neg_next;
  logic [dtfp_pkg::MANT_W-1:0]         mantissa, mantissa_next;
  logic [dtfp_pkg::FCNT_W-1:0]         frac_count, frac_count_next;
  logic                                mant_sat, mant_sat_next;
  logic [dtfp_pkg::EXPD_W-1:0]         exp_digit, exp_digit_next;
  logic                                exp_bad, exp_bad_next;

  logic                                is_dig;
  logic                                is_ws;
  logic                                add_en;
  logic [ACC_W-1:0]                    m10;

  always_comb begin
    is_dig = char_code inside {[CH_ZERO:CH_NINE]};
    is_ws  = char_code inside {[CH_TAB:CH_CR], CH_SPACE};
    m10 = (ACC_W'(mantissa) << 3) + (ACC_W'(mantissa) << 1) + ACC_W'(char_code[3:0]);

    ex_state_next  = ex_state;
    exp_digit_next = exp_digit;
    exp_bad_next   = exp_bad;
    case (ex_state)
      dtfp_pkg::EX_SEARCH: begin
        if (char_code == CH_E_LOW || char_code == CH_E_UP) begin
          ex_state_next = dtfp_pkg::EX_NEXT;
        end
      end
      dtfp_pkg::EX_NEXT: begin
        if (is_dig) begin
          exp_digit_next = char_code[3:0];
        end else begin
          exp_bad_next = 1'b1;
        end
        ex_state_next = dtfp_pkg::EX_DONE;
      end
      default: ;
    endcase

    phase_next      = phase;
    neg_next        = neg;
    frac_count_next = frac_count;
    add_en          = 1'b0;
    case (phase)
      dtfp_pkg::PH_WS: begin
        if (is_ws) begin
          phase_next = dtfp_pkg::PH_WS;
        end else if (char_code == CH_MINUS) begin
          neg_next   = 1'b1;
          phase_next = dtfp_pkg::PH_INT;
        end else if (char_code == CH_PLUS) begin
          phase_next = dtfp_pkg::PH_INT;
        end else if (is_dig) begin
          add_en     = 1'b1;
          phase_next = dtfp_pkg::PH_INT;
        end else if (char_code == CH_POINT) begin
          phase_next = dtfp_pkg::PH_FRAC;
        end else begin
          phase_next = dtfp_pkg::PH_DONE;
        end
      end
      dtfp_pkg::PH_INT: begin
        if (is_dig) begin
          add_en = 1'b1;
        end else if (char_code == CH_POINT) begin
          phase_next = dtfp_pkg::PH_FRAC;
        end else begin
          phase_next = dtfp_pkg::PH_DONE;
        end
      end
      dtfp_pkg::PH_FRAC: begin
        if (is_dig) begin
          if (frac_count < dtfp_pkg::MAX_FRACTION_DIGITS) begin
            add_en          = 1'b1;
            frac_count_next = frac_count + 1'b1;
          end
        end else begin
          phase_next = dtfp_pkg::PH_DONE;
        end
      end
      default: ;
    endcase

    mantissa_next = mantissa;
    mant_sat_next = mant_sat;
    if (add_en && !mant_sat) begin
      if (m10[ACC_W-1:dtfp_pkg::MANT_W] != '0) begin
        mant_sat_next = 1'b1;
        mantissa_next = '1;
      end else begin
        mantissa_next = m10[dtfp_pkg::MANT_W-1:0];
      end
    end

    snap.neg        = neg_next;
    snap.mantissa   = mantissa_next;
    snap.frac_count = frac_count_next;
    snap.mant_sat   = mant_sat_next;
    snap.exp_digit  = exp_digit_next;
    snap.exp_bad    = exp_bad_next || (ex_state_next == dtfp_pkg::EX_NEXT);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_char)) begin
      phase      <= dtfp_pkg::PH_WS;
      ex_state   <= dtfp_pkg::EX_SEARCH;
      neg        <= 1'b0;
      mantissa   <= '0;
      frac_count <= '0;
      mant_sat   <= 1'b0;
      exp_digit  <= '0;
      exp_bad    <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      ex_state   <= ex_state_next;
      neg        <= neg_next;
      mantissa   <= mantissa_next;
      frac_count <= frac_count_next;
      mant_sat   <= mant_sat_next;
      exp_digit  <= exp_digit_next;
      exp_bad    <= exp_bad_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dtfp_scale_unit.sv =====
`default_nettype none
module dtfp_scale_unit #(
  parameter int unsigned RESULT_WIDTH = dtfp_pkg::DEF_RESULT_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire dtfp_pkg::scan_snap_t          snap,
  input  wire logic [dtfp_pkg::FBITS_W-1:0]  fraction_bits,
  output logic                               idle,
  output logic                               res_valid,
  input  wire logic                          res_take,
  output logic [RESULT_WIDTH-1:0]            res_mag,
  output logic                               res_neg,
  output logic                               res_ovf,
  output logic                               res_exp_bad
);

  localparam int unsigned PP_W  = dtfp_pkg::SCALE_W + 32;
  localparam int unsigned CNT_W = $clog2(dtfp_pkg::PROD_W + (1 << dtfp_pkg::FBITS_W));
  localparam int unsigned DEN_W = dtfp_pkg::DEN_W;

  dtfp_pkg::scale_state_t               state, state_next;

  logic [dtfp_pkg::MANT_W-1:0]          mant;
  logic [dtfp_pkg::SCALE_W-1:0]         scale;
  logic [DEN_W-1:0]                     den;
  logic [PP_W-1:0]                      plo;
  logic [PP_W-1:0]                      phi;
  logic [dtfp_pkg::PROD_W-1:0]          prod_sh;
  logic [DEN_W-1:0]                     rem;
  logic [RESULT_WIDTH-1:0]              q;
  logic [CNT_W-1:0]                     step;
  logic                                 neg;
  logic                                 ovf;
  logic                                 exp_bad;

  logic [31:0]                          mul_a;
  logic [PP_W-1:0]                      mul_p;
  logic [DEN_W:0]                       trial;
  logic                                 ge;
  logic [DEN_W:0]                       rem_wide;
  logic [RESULT_WIDTH:0]                q_next;
  logic [RESULT_WIDTH-1:0]              lim;
  logic [RESULT_WIDTH-1:0]              lim_start;
  logic                                 over;
  logic [CNT_W-1:0]                     last_idx;
  logic [dtfp_pkg::FCNT_W-1:0]          fd;

  function automatic logic [RESULT_WIDTH-1:0] limit_of(input logic n);
    return n ? {1'b1, {(RESULT_WIDTH-1){1'b0}}} : {1'b0, {(RESULT_WIDTH-1){1'b1}}};
  endfunction

  always_comb begin
    mul_a     = (state == dtfp_pkg::SC_MUL_LO) ? mant[31:0] : mant[63:32];
    mul_p     = PP_W'(mul_a) * PP_W'(scale);
    trial     = {rem, prod_sh[dtfp_pkg::PROD_W-1]};
    ge        = trial >= {1'b0, den};
    rem_wide  = ge ? (trial - {1'b0, den}) : trial;
    q_next    = {q, ge};
    lim       = limit_of(neg);
    lim_start = limit_of(snap.neg);
    over      = q_next > {1'b0, lim};
    last_idx  = CNT_W'(dtfp_pkg::PROD_W - 1) + CNT_W'(fraction_bits);
    fd        = (snap.frac_count > dtfp_pkg::MAX_FRACTION_DIGITS) ?
                dtfp_pkg::MAX_FRACTION_DIGITS : snap.frac_count;

    state_next = state;
    case (state)
      dtfp_pkg::SC_IDLE: begin
        if (start) begin
          state_next = snap.mant_sat ? dtfp_pkg::SC_DONE : dtfp_pkg::SC_MUL_LO;
        end
      end
      dtfp_pkg::SC_MUL_LO: state_next = dtfp_pkg::SC_MUL_HI;
      dtfp_pkg::SC_MUL_HI: state_next = dtfp_pkg::SC_SUM;
      dtfp_pkg::SC_SUM:    state_next = dtfp_pkg::SC_DIV;
      dtfp_pkg::SC_DIV: begin
        if (over || step == last_idx) begin
          state_next = dtfp_pkg::SC_DONE;
        end
      end
      dtfp_pkg::SC_DONE: begin
        if (res_take) begin
          state_next = dtfp_pkg::SC_IDLE;
        end
      end
      default: state_next = dtfp_pkg::SC_IDLE;
    endcase

    idle        = (state == dtfp_pkg::SC_IDLE);
    res_valid   = (state == dtfp_pkg::SC_DONE);
    res_mag     = q;
    res_neg     = neg;
    res_ovf     = ovf;
    res_exp_bad = exp_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtfp_pkg::SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      dtfp_pkg::SC_IDLE: begin
        if (start) begin
          neg     <= snap.neg;
          exp_bad <= snap.exp_bad;
          mant    <= snap.mantissa;
          scale   <= snap.exp_bad ? dtfp_pkg::SCALE_W'(1) :
                     dtfp_pkg::SCALE_W'(dtfp_pkg::pow10({1'b0, snap.exp_digit}));
          den     <= dtfp_pkg::pow10(fd);
          rem     <= '0;
          step    <= '0;
          q       <= snap.mant_sat ? lim_start : '0;
          ovf     <= snap.mant_sat;
        end
      end
      dtfp_pkg::SC_MUL_LO: plo <= mul_p;
      dtfp_pkg::SC_MUL_HI: phi <= mul_p;
      dtfp_pkg::SC_SUM: begin
        prod_sh <= dtfp_pkg::PROD_W'(plo) + (dtfp_pkg::PROD_W'(phi) << 32);
      end
      dtfp_pkg::SC_DIV: begin
        if (over) begin
          q   <= lim;
          ovf <= 1'b1;
        end else begin
          q       <= q_next[RESULT_WIDTH-1:0];
          rem     <= rem_wide[DEN_W-1:0];
          prod_sh <= prod_sh << 1;
          step    <= step + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/decimal_text_to_fixed_parser.sv =====
`default_nettype none
// Decimal text to signed fixed-point converter. Text arrives one character
// per item. The item marked last_char starts the scaling sequence, during
// which in_ready is low: the mantissa is multiplied by the exponent power
// of ten on one shared 32-bit multiplier (low half, then high half, then
// one add), then a restoring divider by the fraction power of ten retires
// one quotient bit per cycle, 94 + fraction_bits bits in all, stopping
// early on saturation. A mantissa that already saturated skips the scaling
// and goes straight to the result. The finished item sits in an output
// register, so the next string may start while it waits to be taken.
// fraction_bits is register 0 of the APB port and must only change while
// the block is idle.
module decimal_text_to_fixed_parser #(
  parameter int unsigned RESULT_WIDTH = dtfp_pkg::DEF_RESULT_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_code,
  input  wire logic        last_char,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      fixed_value,
  output logic             overflow_flag,
  output logic             exponent_error
);

  localparam logic REG_FRACTION_BITS = 1'b0;

  logic [dtfp_pkg::FBITS_W-1:0] fraction_bits;
  logic                         accept;
  logic                         unit_idle;
  logic                         res_valid;
  logic                         res_take;
  logic [RESULT_WIDTH-1:0]      res_mag;
  logic                         res_neg;
  logic                         res_ovf;
  logic                         res_exp_bad;
  dtfp_pkg::scan_snap_t         snap;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_FRACTION_BITS) ? 32'(fraction_bits) : '0;
  assign in_ready = unit_idle;
  assign accept   = in_valid && in_ready;
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      fraction_bits <= dtfp_pkg::FBITS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRACTION_BITS) begin
      fraction_bits <= pwdata[dtfp_pkg::FBITS_W-1:0];
    end
  end

  dtfp_char_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .last_char (last_char),
    .snap      (snap)
  );

  dtfp_scale_unit #(
    .RESULT_WIDTH (RESULT_WIDTH)
  ) u_scale (
    .clk           (clk),
    .rst           (rst),
    .start         (accept && last_char),
    .snap          (snap),
    .fraction_bits (fraction_bits),
    .idle          (unit_idle),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res_mag       (res_mag),
    .res_neg       (res_neg),
    .res_ovf       (res_ovf),
    .res_exp_bad   (res_exp_bad)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      fixed_value    <= res_neg ? (64'd0 - 64'(res_mag)) : 64'(res_mag);
      overflow_flag  <= res_ovf;
      exponent_error <= res_exp_bad;
    end
  end

endmodule
`default_nettype wire

// ===== dv/decimal_text_to_fixed_parser_tb.sv =====
module decimal_text_to_fixed_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_E_LO  = 8'h65;

  localparam logic [2:0] ADDR_FRACTION_BITS = 3'd0;

  localparam int MAX_WAIT        = 12;
  localparam int LONG_HOLD       = 600;
  localparam int SETTLE          = 200;
  localparam int CHARS_PER_PHASE = 115;
  localparam int NUM_PHASES      = 7;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  typedef struct packed {
    logic [63:0] value;
    logic        ovf;
    logic        exp_err;
  } fixed_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code = '0;
  logic        last_char = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] fixed_value;
  logic        overflow_flag;
  logic        exponent_error;

  decimal_text_to_fixed_parser i_dut (.*);

  always #5 clk = ~clk;

  // parser state mirror
  dtfp_pkg::phase_t     num_phase = dtfp_pkg::PH_WS;
  dtfp_pkg::exp_state_t exp_phase = dtfp_pkg::EX_SEARCH;
  logic        is_neg = 1'b0;
  logic [63:0] mant = '0;
  logic [4:0]  frac_digits = '0;
  logic        mant_full = 1'b0;
  logic [3:0]  exp_digit = '0;
  logic        exp_bad = 1'b0;
  logic [5:0]  frac_bits = dtfp_pkg::FBITS_RESET;

  fixed_result_t fixed_expect_q[$];
  text_char_t    text_q[$];

  int chars_queued = 0;
  int chars_accepted = 0;
  int strings_parsed = 0;
  int results_checked = 0;
  int mismatches = 0;

  bit         in_taken = 1'b0;
  bit         out_taken = 1'b0;
  bit         offering = 1'b0;
  bit         send_quiet = 1'b0;
  bit         recv_quiet = 1'b0;
  bit         hold_request = 1'b0;
  int         send_wait = 0;
  int         recv_wait = 0;
  text_char_t cur = '0;
  fixed_result_t exp_r;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
  endfunction

  task automatic push_digit(input logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - CH_0);
    if (!mant_full) begin
      if (mant > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
        mant_full = 1'b1;
        mant = '1;
      end else begin
        mant = mant * 64'd10 + d;
      end
    end
  endtask

  function automatic fixed_result_t scale_result();
    fixed_result_t r;
    logic [63:0]   lim;
    logic [63:0]   mul;
    logic [63:0]   den;
    logic [63:0]   mag;
    logic [191:0]  q;
    r.ovf = 1'b0;
    r.exp_err = exp_bad;
    lim = is_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    mul = 64'd1;
    den = 64'd1;
    if (!exp_bad) repeat (exp_digit) mul = mul * 64'd10;
    repeat (frac_digits) den = den * 64'd10;
    if (mant_full) begin
      r.ovf = 1'b1;
      mag = lim;
    end else begin
      q = ((192'(mant) * 192'(mul)) << frac_bits) / 192'(den);
      if (q > 192'(lim)) begin
        r.ovf = 1'b1;
        mag = lim;
      end else begin
        mag = q[63:0];
      end
    end
    r.value = is_neg ? -mag : mag;
    return r;
  endfunction

  task automatic parse_char(input logic [7:0] c, input logic last);
    case (exp_phase)
      dtfp_pkg::EX_SEARCH: begin
        if (c == CH_E_LO || c == CH_E_UP) exp_phase = dtfp_pkg::EX_NEXT;
      end
      dtfp_pkg::EX_NEXT: begin
        if (is_digit(c)) exp_digit = 4'(c - CH_0);
        else exp_bad = 1'b1;
        exp_phase = dtfp_pkg::EX_DONE;
      end
      default: ;
    endcase
    case (num_phase)
      dtfp_pkg::PH_WS: if (!is_blank(c)) begin
        if (c == CH_MINUS) begin
          is_neg = 1'b1;
          num_phase = dtfp_pkg::PH_INT;
        end else if (c == CH_PLUS) begin
          num_phase = dtfp_pkg::PH_INT;
        end else if (is_digit(c)) begin
          push_digit(c);
          num_phase = dtfp_pkg::PH_INT;
        end else if (c == CH_DOT) begin
          num_phase = dtfp_pkg::PH_FRAC;
        end else begin
          num_phase = dtfp_pkg::PH_DONE;
        end
      end
      dtfp_pkg::PH_INT: begin
        if (is_digit(c)) push_digit(c);
        else if (c == CH_DOT) num_phase = dtfp_pkg::PH_FRAC;
        else num_phase = dtfp_pkg::PH_DONE;
      end
      dtfp_pkg::PH_FRAC: begin
        if (!is_digit(c)) begin
          num_phase = dtfp_pkg::PH_DONE;
        end else if (frac_digits < dtfp_pkg::MAX_FRACTION_DIGITS) begin
          push_digit(c);
          frac_digits++;
        end
      end
      default: ;
    endcase
    if (last) begin
      // e or E as the final character counts as a bad exponent
      if (exp_phase == dtfp_pkg::EX_NEXT) exp_bad = 1'b1;
      fixed_expect_q.push_back(scale_result());
      strings_parsed++;
      num_phase = dtfp_pkg::PH_WS;
      exp_phase = dtfp_pkg::EX_SEARCH;
      is_neg = 1'b0;
      mant = '0;
      frac_digits = '0;
      mant_full = 1'b0;
      exp_digit = '0;
      exp_bad = 1'b0;
    end
  endtask

  task automatic queue_char(input logic [7:0] c, input logic last);
    text_q.push_back('{c, last});
    chars_queued++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    int n;
    n = $urandom_range(0, 5);
    return n == 5 ? CH_SPACE : CH_TAB + 8'(n);
  endfunction

  function automatic logic [7:0] rand_e();
    return $urandom_range(0, 1) ? CH_E_LO : CH_E_UP;
  endfunction

  // mostly well-formed numbers with random content, some pure noise
  task automatic queue_random_text();
    logic [7:0] txt[$];
    int         n_int;
    int         n_frac;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) txt.push_back(rand_blank());
      case ($urandom_range(0, 3))
        0: txt.push_back(CH_MINUS);
        1: txt.push_back(CH_PLUS);
        default: ;
      endcase
      n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 22) : $urandom_range(0, 6);
      repeat (n_int) txt.push_back(rand_digit());
      if ($urandom_range(0, 1)) begin
        txt.push_back(CH_DOT);
        n_frac = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 21) : $urandom_range(0, 6);
        repeat (n_frac) txt.push_back(rand_digit());
      end
      case ($urandom_range(0, 5))
        0, 1: begin
          txt.push_back(rand_e());
          txt.push_back(rand_digit());
        end
        2: begin
          txt.push_back(rand_e());
          if ($urandom_range(0, 1)) txt.push_back(8'($urandom_range(0, 255)));
        end
        default: ;
      endcase
      if ($urandom_range(0, 4) == 0) txt.push_back(8'($urandom_range(0, 255)));
    end
    if (txt.size() == 0) txt.push_back(rand_digit());
    foreach (txt[i]) queue_char(txt[i], i == txt.size() - 1);
  endtask

  task automatic write_fraction_bits(input logic [5:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_FRACTION_BITS;
    pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    frac_bits = v;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (text_q.size() != 0 || offering || fixed_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // character driver
  always @(negedge clk) begin
    if (in_taken) begin
      in_taken = 1'b0;
      offering = 1'b0;
      send_wait = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    end
    if (!rst && !offering) begin
      if (send_wait > 0) begin
        send_wait--;
      end else if (text_q.size() != 0) begin
        cur = text_q.pop_front();
        offering = 1'b1;
      end
    end
    in_valid <= offering;
    char_code <= cur.code;
    last_char <= cur.last;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      parse_char(char_code, last_char);
      in_taken = 1'b1;
      chars_accepted++;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      recv_wait = recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    end
    if (hold_request) begin
      hold_request = 1'b0;
      recv_wait = LONG_HOLD;
    end
    if (recv_wait > 0) begin
      recv_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rst;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      out_taken = 1'b1;
      if (fixed_expect_q.size() == 0) begin
        $error("unexpected result: fixed_value %0d", $signed(fixed_value));
        mismatches++;
      end else begin
        exp_r = fixed_expect_q.pop_front();
        results_checked++;
        if (fixed_value !== exp_r.value) begin
          $error("fixed_value: expected %0d, actual %0d", $signed(exp_r.value),
                 $signed(fixed_value));
          mismatches++;
        end
        if (overflow_flag !== exp_r.ovf) begin
          $error("overflow_flag: expected %0b, actual %0b", exp_r.ovf, overflow_flag);
          mismatches++;
        end
        if (exponent_error !== exp_r.exp_err) begin
          $error("exponent_error: expected %0b, actual %0b", exp_r.exp_err, exponent_error);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [5:0] fb;
    int         target;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset value of fraction_bits
    queue_text("-0");
    queue_text("+9.5e3");
    queue_char(CH_TAB, 1'b0);
    queue_char(CH_CR, 1'b0);
    queue_text(" .5");
    queue_text("1e");
    queue_text("7ex");
    queue_char(8'hFF, 1'b1);
    queue_char(8'h00, 1'b1);
    queue_text("E4");
    queue_text("3e0");
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: fb = 6'd32;
        1: fb = 6'd0;
        5: fb = 6'd8;
        default: fb = 6'($urandom_range(1, 31));
      endcase
      write_fraction_bits(fb);
      send_quiet = (p == 2) || (p == 4) || (p == 5);
      recv_quiet = (p == 3) || (p == 4);
      if (p == 0) queue_text("9e9");
      // receiver stalls long while the sender keeps streaming
      if (p == 2) hold_request = 1'b1;
      target = chars_queued + CHARS_PER_PHASE;
      while (chars_queued < target) queue_random_text();
      drain();
    end

    $display("%0d characters in %0d strings parsed, %0d results checked",
             chars_accepted, strings_parsed, results_checked);
    $display("fraction_bits swept over reset, 0, 8, 32 and random settings");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dtfp_pkg.sv
rtl/dtfp_char_scan.sv
rtl/dtfp_scale_unit.sv
rtl/decimal_text_to_fixed_parser.sv
dv/decimal_text_to_fixed_parser_tb.sv
